// File: src/floppy_controller_command_engine_macros.svh
// assertion macros for the floppy controller command engine
// used by the rtl modules that carry concurrent checks; no other dependencies
`ifndef FLOPPY_CONTROLLER_COMMAND_ENGINE_MACROS_SVH
`define FLOPPY_CONTROLLER_COMMAND_ENGINE_MACROS_SVH
`ifndef ASSERT_OFF
// check outside reset
`define FCE_ASSERT(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// check at every edge, reset included
`define FCE_ASSERT_ALWAYS(name, clk, prop, msg) \
    name: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define FCE_ASSERT(name, clk, rst_n, prop, msg)
`define FCE_ASSERT_ALWAYS(name, clk, prop, msg)
`endif
`endif

// File: src/fce_pkg.sv
// shared types and constants of the floppy controller command engine
// no dependencies
package fce_pkg;

    localparam logic [15:0] PORT_DOR    = 16'h03F2;
    localparam logic [15:0] PORT_STATUS = 16'h03F4;
    localparam logic [15:0] PORT_DATA   = 16'h03F5;
    localparam logic [15:0] PORT_DIR    = 16'h03F7;

    localparam logic [7:0] MSR_COMMAND = 8'h80;
    localparam logic [7:0] MSR_PARAMS  = 8'h90;
    localparam logic [7:0] MSR_RESULT  = 8'hD0;

    localparam logic [7:0] ST0_RESET   = 8'hC0;
    localparam logic [7:0] ST0_SEEK_END = 8'h20;
    localparam logic [7:0] ST0_ABNORMAL = 8'h40;
    localparam logic [7:0] ST1_NO_DATA = 8'h20;
    localparam logic [7:0] ST3_TRACK0  = 8'h10;
    localparam logic [14:0] BASE_SECTOR_LEN = 15'd128;

    localparam logic [4:0] CMD_SPECIFY     = 5'h03;
    localparam logic [4:0] CMD_SENSE_DRIVE = 5'h04;
    localparam logic [4:0] CMD_READ_DATA   = 5'h06;
    localparam logic [4:0] CMD_RECALIBRATE = 5'h07;
    localparam logic [4:0] CMD_SENSE_INT   = 5'h08;
    localparam logic [4:0] CMD_SEEK        = 5'h0F;

    localparam logic [2:0] CFG_HEAD_COUNT  = 3'd0;
    localparam logic [2:0] CFG_SECTORS     = 3'd1;
    localparam logic [2:0] CFG_SECTOR_BYTES = 3'd2;
    localparam logic [2:0] CFG_IMAGE_BYTES = 3'd3;
    localparam logic [2:0] CFG_HOST_BYTES  = 3'd4;

    typedef enum logic [2:0] {
        K_RD_STATUS,
        K_RD_DATA,
        K_RD_ZERO,
        K_RD_FF,
        K_WR_RESET,
        K_WR_DATA,
        K_WR_NOP
    } access_kind_t;

    typedef struct packed {
        access_kind_t kind;
        logic [7:0]   wr_byte;
        logic [23:0]  phys_addr;
    } access_t;

endpackage

// File: src/fce_front.sv
// front end: accepts port accesses, classifies them and queues them
// depends on fce_pkg
module fce_front
    import fce_pkg::*;
#(
    parameter int ADDR_BITS = 24
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,
    input  logic [0:0]  s_tuser,
    output logic        q_valid,
    output access_t     q_item,
    input  logic        q_pop
);

    localparam logic [23:0] ADDR_MASK = (ADDR_BITS >= 24) ? {24{1'b1}}
                                        : 24'((64'd1 << ADDR_BITS) - 64'd1);

    access_t    slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    access_t    item;
    logic       push;
    logic [15:0] port;

    assign port = s_tdata[15:0];

    always_comb begin
        item.wr_byte   = s_tdata[23:16];
        item.phys_addr = s_tdata[47:24] & ADDR_MASK;
        if (s_tuser[0] == 1'b0) begin
            if (port == PORT_STATUS)    item.kind = K_RD_STATUS;
            else if (port == PORT_DATA) item.kind = K_RD_DATA;
            else if (port == PORT_DIR)  item.kind = K_RD_ZERO;
            else                        item.kind = K_RD_FF;
        end else begin
            if (port == PORT_DOR && !s_tdata[18]) item.kind = K_WR_RESET;
            else if (port == PORT_DATA)           item.kind = K_WR_DATA;
            else                                  item.kind = K_WR_NOP;
        end
    end

    assign s_tready = (count_reg != 2'd2);
    assign push     = s_tvalid && s_tready;
    assign q_valid  = (count_reg != 2'd0);
    assign q_item   = slot_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                slot_reg[wr_ptr_reg] <= item;
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (q_pop) rd_ptr_reg <= ~rd_ptr_reg;
            count_reg <= count_reg + 2'(push) - 2'(q_pop);
        end
    end

endmodule

// File: src/fce_back.sv
// back end: command, parameter and result phases, read data offset and range checks
// depends on fce_pkg and the assertion macro header
`include "floppy_controller_command_engine_macros.svh"
module fce_back
    import fce_pkg::*;
#(
    parameter int PARAM_SLOTS  = 8,
    parameter int RESULT_SLOTS = 7,
    parameter int DRIVE_COUNT  = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        q_valid,
    input  access_t     q_item,
    output logic        q_pop,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [24:0] cfg_wdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata
);

    localparam int PCW = $clog2(PARAM_SLOTS + 1);
    localparam int PIW = $clog2(PARAM_SLOTS);
    localparam int RCW = $clog2(RESULT_SLOTS + 1);
    localparam int RIW = $clog2(RESULT_SLOTS);

    typedef enum logic [2:0] {S_IDLE, S_RUN, S_MUL2, S_MUL3, S_CHECK} state_t;
    typedef enum logic [1:0] {PH_COMMAND, PH_PARAMS, PH_RESULT} phase_t;

    state_t      state_reg;
    phase_t      phase_reg;
    logic [7:0]  cmd_reg;
    logic [7:0]  param_reg [PARAM_SLOTS];
    logic [PCW-1:0] pcount_reg;
    logic [3:0]  pneed_reg;
    logic [7:0]  res_reg [RESULT_SLOTS];
    logic [RCW-1:0] rlen_reg;
    logic [RCW-1:0] ridx_reg;
    logic [7:0]  track_reg [DRIVE_COUNT];
    logic [7:0]  st0_reg;
    logic [7:0]  cyl_reg;
    logic        pending_reg;
    logic [23:0] phys_reg;
    logic [26:0] mul_reg;

    logic [1:0]  heads_reg;
    logic [5:0]  spt_reg;
    logic [10:0] sbytes_reg;
    logic [23:0] image_reg;
    logic [24:0] host_reg;

    logic        out_valid_reg;
    logic [7:0]  out_rb_reg;
    logic        out_irq_reg;
    logic        out_pend_reg;
    logic        out_xfer_reg;
    logic [23:0] out_off_reg;
    logic [23:0] out_addr_reg;
    logic [14:0] out_len_reg;

    logic [1:0]  drv;
    logic        drv_ok;
    logic [7:0]  drv_track;
    logic [7:0]  msr;
    logic [14:0] sec_len;
    logic        xfer_ok;
    logic        take;
    logic [PCW-1:0] pcount_inc;
    logic        pstore;

    assign drv    = param_reg[0][1:0];
    assign drv_ok = 3'(drv) < 3'(DRIVE_COUNT);

    always_comb begin
        drv_track = 8'd0;
        for (int i = 0; i < DRIVE_COUNT; i++) begin
            if (drv == 2'(i)) drv_track = track_reg[i];
        end
    end

    always_comb begin
        case (phase_reg)
            PH_PARAMS: msr = MSR_PARAMS;
            PH_RESULT: msr = MSR_RESULT;
            default:   msr = MSR_COMMAND;
        endcase
    end

    assign sec_len = BASE_SECTOR_LEN << param_reg[4][2:0];
    assign xfer_ok = (param_reg[3] != 8'd0) && (param_reg[4] <= 8'd7)
                     && (28'(mul_reg) + 28'(sec_len) <= 28'(image_reg))
                     && (26'(phys_reg) + 26'(sec_len) <= 26'(host_reg));

    assign take   = (state_reg == S_IDLE) && q_valid && (!out_valid_reg || m_tready);
    assign q_pop  = take;
    assign pstore = pcount_reg < PCW'(PARAM_SLOTS);
    assign pcount_inc = pcount_reg + PCW'(pstore);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            phase_reg     <= PH_COMMAND;
            cmd_reg       <= 8'd0;
            pcount_reg    <= '0;
            pneed_reg     <= 4'd0;
            rlen_reg      <= '0;
            ridx_reg      <= '0;
            st0_reg       <= 8'd0;
            cyl_reg       <= 8'd0;
            pending_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            heads_reg     <= 2'd2;
            spt_reg       <= 6'd18;
            sbytes_reg    <= 11'd512;
            image_reg     <= 24'd0;
            host_reg      <= 25'd1048576;
            for (int i = 0; i < DRIVE_COUNT; i++) track_reg[i] <= 8'd0;
        end else begin
            if (cfg_we) begin
                case (cfg_addr)
                    CFG_HEAD_COUNT:   heads_reg  <= cfg_wdata[1:0];
                    CFG_SECTORS:      spt_reg    <= cfg_wdata[5:0];
                    CFG_SECTOR_BYTES: sbytes_reg <= cfg_wdata[10:0];
                    CFG_IMAGE_BYTES:  image_reg  <= cfg_wdata[23:0];
                    CFG_HOST_BYTES:   host_reg   <= cfg_wdata;
                    default: ;
                endcase
            end
            if (m_tready) out_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE: begin
                    if (take) begin
                        phys_reg     <= q_item.phys_addr;
                        out_rb_reg   <= 8'd0;
                        out_irq_reg  <= 1'b0;
                        out_pend_reg <= pending_reg;
                        out_xfer_reg <= 1'b0;
                        out_off_reg  <= 24'd0;
                        out_addr_reg <= 24'd0;
                        out_len_reg  <= 15'd0;
                        out_valid_reg <= 1'b1;
                        unique case (q_item.kind)
                            K_RD_STATUS: out_rb_reg <= msr;
                            K_RD_FF:     out_rb_reg <= 8'hFF;
                            K_RD_DATA: begin
                                if (phase_reg == PH_RESULT && ridx_reg < rlen_reg
                                        && ridx_reg < RCW'(RESULT_SLOTS)) begin
                                    out_rb_reg <= res_reg[ridx_reg[RIW-1:0]];
                                    ridx_reg   <= ridx_reg + 1'b1;
                                    if (ridx_reg + 1'b1 >= rlen_reg) begin
                                        phase_reg  <= PH_COMMAND;
                                        pcount_reg <= '0;
                                        pneed_reg  <= 4'd0;
                                    end
                                end
                            end
                            K_WR_RESET: begin
                                st0_reg      <= ST0_RESET;
                                cyl_reg      <= 8'd0;
                                pending_reg  <= 1'b0;
                                out_pend_reg <= 1'b0;
                                phase_reg    <= PH_COMMAND;
                                pcount_reg   <= '0;
                                pneed_reg    <= 4'd0;
                            end
                            K_WR_DATA: begin
                                if (phase_reg == PH_COMMAND) begin
                                    cmd_reg    <= q_item.wr_byte;
                                    pcount_reg <= '0;
                                    phase_reg  <= PH_PARAMS;
                                    unique case (q_item.wr_byte[4:0])
                                        CMD_SPECIFY, CMD_SEEK: pneed_reg <= 4'd2;
                                        CMD_SENSE_DRIVE, CMD_RECALIBRATE: pneed_reg <= 4'd1;
                                        CMD_READ_DATA: pneed_reg <= 4'd8;
                                        CMD_SENSE_INT: begin
                                            pneed_reg     <= 4'd0;
                                            phase_reg     <= PH_COMMAND;
                                            out_valid_reg <= 1'b0;
                                            state_reg     <= S_RUN;
                                        end
                                        default: begin
                                            pneed_reg <= 4'd0;
                                            phase_reg <= PH_COMMAND;
                                        end
                                    endcase
                                end else if (phase_reg == PH_PARAMS) begin
                                    if (pstore) param_reg[pcount_reg[PIW-1:0]] <= q_item.wr_byte;
                                    pcount_reg <= pcount_inc;
                                    if (5'(pcount_inc) >= 5'(pneed_reg)) begin
                                        out_valid_reg <= 1'b0;
                                        state_reg     <= S_RUN;
                                    end
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_RUN: begin
                    out_irq_reg   <= 1'b0;
                    out_pend_reg  <= pending_reg;
                    out_valid_reg <= 1'b1;
                    state_reg     <= S_IDLE;
                    unique case (cmd_reg[4:0])
                        CMD_RECALIBRATE, CMD_SEEK: begin
                            for (int i = 0; i < DRIVE_COUNT; i++) begin
                                if (drv == 2'(i)) begin
                                    track_reg[i] <= (cmd_reg[4:0] == CMD_SEEK)
                                                    ? param_reg[1] : 8'd0;
                                end
                            end
                            st0_reg      <= ST0_SEEK_END | 8'(drv);
                            cyl_reg      <= (cmd_reg[4:0] == CMD_SEEK) ? param_reg[1] : 8'd0;
                            pending_reg  <= 1'b1;
                            out_pend_reg <= 1'b1;
                            out_irq_reg  <= 1'b1;
                            phase_reg    <= PH_COMMAND;
                            pcount_reg   <= '0;
                            pneed_reg    <= 4'd0;
                        end
                        CMD_SENSE_DRIVE: begin
                            res_reg[0] <= ST0_SEEK_END | 8'(drv)
                                          | ((!drv_ok || drv_track == 8'd0)
                                             ? ST3_TRACK0 : 8'd0);
                            rlen_reg  <= RCW'(1);
                            ridx_reg  <= '0;
                            phase_reg <= PH_RESULT;
                        end
                        CMD_SENSE_INT: begin
                            res_reg[0]   <= st0_reg;
                            res_reg[1]   <= cyl_reg;
                            rlen_reg     <= RCW'(2);
                            ridx_reg     <= '0;
                            phase_reg    <= PH_RESULT;
                            pending_reg  <= 1'b0;
                            out_pend_reg <= 1'b0;
                        end
                        CMD_READ_DATA: begin
                            out_valid_reg <= 1'b0;
                            mul_reg   <= 27'(param_reg[1] * heads_reg) + 27'(param_reg[2][0]);
                            state_reg <= S_MUL2;
                        end
                        default: begin
                            phase_reg  <= PH_COMMAND;
                            pcount_reg <= '0;
                            pneed_reg  <= 4'd0;
                        end
                    endcase
                end
                S_MUL2: begin
                    mul_reg   <= 27'(mul_reg[9:0] * spt_reg) + 27'(param_reg[3]) - 27'd1;
                    state_reg <= S_MUL3;
                end
                S_MUL3: begin
                    mul_reg   <= 27'(mul_reg[15:0] * sbytes_reg);
                    state_reg <= S_CHECK;
                end
                S_CHECK: begin
                    for (int i = 0; i < RESULT_SLOTS; i++) begin
                        case (i)
                            0: res_reg[i] <= xfer_ok ? 8'(drv) : (8'(drv) | ST0_ABNORMAL);
                            1: res_reg[i] <= xfer_ok ? 8'd0 : ST1_NO_DATA;
                            2: res_reg[i] <= 8'd0;
                            3: res_reg[i] <= param_reg[1];
                            4: res_reg[i] <= {7'd0, param_reg[2][0]};
                            5: res_reg[i] <= param_reg[3];
                            6: res_reg[i] <= param_reg[4];
                            default: ;
                        endcase
                    end
                    rlen_reg      <= RCW'(7);
                    ridx_reg      <= '0;
                    phase_reg     <= PH_RESULT;
                    pending_reg   <= 1'b1;
                    out_pend_reg  <= 1'b1;
                    out_irq_reg   <= 1'b1;
                    out_xfer_reg  <= xfer_ok;
                    out_off_reg   <= xfer_ok ? mul_reg[23:0] : 24'd0;
                    out_addr_reg  <= xfer_ok ? phys_reg : 24'd0;
                    out_len_reg   <= xfer_ok ? sec_len : 15'd0;
                    out_valid_reg <= 1'b1;
                    state_reg     <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, out_len_reg, out_addr_reg, out_off_reg,
                       out_xfer_reg, out_pend_reg, out_irq_reg, out_rb_reg};

    `FCE_ASSERT(a_busy_out_empty, aclk, aresetn, (state_reg != S_IDLE) |-> !out_valid_reg, "result register busy during command execution")
    `FCE_ASSERT(a_result_nonempty, aclk, aresetn, (phase_reg == PH_RESULT) |-> (rlen_reg != '0), "result phase with no result bytes")
    `FCE_ASSERT(a_params_need, aclk, aresetn, (phase_reg == PH_PARAMS) |-> (pneed_reg != 4'd0), "parameter phase with nothing needed")
    `FCE_ASSERT_ALWAYS(a_xfer_irq, aclk, (out_valid_reg && out_xfer_reg) |-> (out_irq_reg && out_pend_reg), "transfer without interrupt")

endmodule

// File: src/floppy_controller_command_engine.sv
// Floppy controller command engine: port accesses in on s_, one result per access out on m_.
// s_tuser[0] is the access kind (0 read, 1 write). A write to the data port drives the
// command and parameter phases; reads of the data port drain the result bytes.
// Each accepted access yields exactly one result transfer, in order.
// From accept to m_tvalid an access passes the queue slot and the result register; a data
// write completing a simple command also passes S_RUN, and a read data command passes S_RUN,
// S_MUL2 and S_MUL3 (three multiply stages) and the range check in S_CHECK. One access is
// executed at a time; a two-entry queue behind s_tready keeps accepting while the back end
// works or m_ is stalled. If m_tready stays low the result register holds and the back end
// stops, then the queue fills and s_tready drops. The user must write configuration through
// cfg_we/cfg_addr/cfg_wdata only while idle; the block does not enforce it. aresetn
// (synchronous, low) empties the queue and the result register and restores the command
// phase, zero tracks and the geometry defaults. Depends on fce_pkg, fce_front and fce_back.
module floppy_controller_command_engine
    import fce_pkg::*;
#(
    parameter int PARAM_SLOTS  = 8,
    parameter int RESULT_SLOTS = 7,
    parameter int DRIVE_COUNT  = 4,
    parameter int ADDR_BITS    = 24
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // port_number, write_byte, dma_target
    input  logic [0:0]  s_tuser,   // opcode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,   // read_byte, irq_raise, int_pending, xfer_start,
                                   // xfer_image_offset, xfer_memory_addr, xfer_length
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [24:0] cfg_wdata
);

    logic    q_valid;
    access_t q_item;
    logic    q_pop;

    fce_front #(.ADDR_BITS(ADDR_BITS)) u_front (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop)
    );

    fce_back #(
        .PARAM_SLOTS(PARAM_SLOTS), .RESULT_SLOTS(RESULT_SLOTS), .DRIVE_COUNT(DRIVE_COUNT)
    ) u_back (
        .aclk(aclk), .aresetn(aresetn),
        .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

endmodule
